### rtl/core/ppc_pkg.sv
// Shared types and constants for the pressure pump controller.
// No dependencies; used by the controller top level and its checker.
`default_nettype none

package ppc_pkg;

  // Register map: register i sits at byte address 4*i.
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    REG_SETPOINT_ONE    = 3'd0,
    REG_SETPOINT_TWO    = 3'd1,
    REG_SETPOINT_THREE  = 3'd2,
    REG_PRESSURE_MIN    = 3'd3,
    REG_PRESSURE_MAX    = 3'd4,
    REG_TOGGLE_INTERVAL = 3'd5,
    REG_KP_Q16          = 3'd6,
    REG_NONE            = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_ALARM = 2'd2
  } mode_t;

  localparam logic [11:0] SetpointOneRst   = 12'd800;
  localparam logic [11:0] SetpointTwoRst   = 12'd1100;
  localparam logic [11:0] SetpointThreeRst = 12'd1400;
  localparam logic [11:0] PressureMinRst   = 12'd300;
  localparam logic [11:0] PressureMaxRst   = 12'd2000;
  localparam logic [13:0] ToggleRst        = 14'd10000;
  localparam logic [15:0] KpRst            = 16'd13108;

  localparam logic [13:0] PreloadGap = 14'd500;
  localparam logic [13:0] TicksMax   = 14'd16383;
  localparam logic [11:0] DutyMin    = 12'd21;
  localparam logic [11:0] DutyFull   = 12'd100;
  localparam logic [5:0]  BuzzOnDuty = 6'd50;

  // Output tdata bit positions, highest field first.
  localparam int unsigned OutRedBit   = 15;
  localparam int unsigned OutGreenBit = 14;

endpackage

`default_nettype wire

### rtl/core/pressure_pump_controller_with_alarm.sv
// Pressure pump controller with alarm buzzer: top level.
// Depends on ppc_pkg for register codes, mode type and constants.
`default_nettype none

// How to use this block:
// Each transaction on the in_ stream carries one sample: a 12-bit pressure
// reading, the tank level bit, three knob pins and a 100 us tick flag. Each
// accepted sample produces exactly one transaction on the out_ stream with
// the motor duty, buzzer duty, relay and LED bits and the selected set point.
// A sample enters an input register, then the controller logic (limit
// compares, knob priority, one 12x16 multiply and the alarm counter) runs
// combinationally into the output register. The block takes one sample
// every cycle while the receiver does not stall; the mode and buzzer
// counter update as each sample moves into the output register.
// When the receiver stalls, the output register holds its transaction, the
// input register fills, and in_tready drops until out_tready returns; no
// sample is lost or repeated.
// The APB port writes the seven configuration registers at byte addresses
// 0x00 to 0x18 and reads them back; writes are meant for idle periods only.
// Reset (synchronous, rst_n low) empties both registers, restores the
// register defaults and returns the controller to its start mode with the
// buzzer off and the alarm counter at zero.
module pressure_pump_controller_with_alarm (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // in_tdata: pressure[11:0], level_ok[12], knob[15:13], tick[16], zero pad
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [23:0]               in_tdata,
  // out_tdata: motor_duty[6:0], buzzer_duty[12:7], relay_on[13],
  // green_led[14], red_led[15], set_point[27:16], zero pad
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [31:0]                    out_tdata,
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [ppc_pkg::AddrW-1:0] cfg_paddr,
  input  wire logic [ppc_pkg::DataW-1:0] cfg_pwdata,
  output logic [ppc_pkg::DataW-1:0]      cfg_prdata,
  output logic                           cfg_pready
);

  // Configuration registers.
  logic [11:0] sp_one_r, sp_two_r, sp_three_r, p_min_r, p_max_r;
  logic [13:0] toggle_r;
  logic [15:0] kp_r;

  ppc_pkg::reg_idx_t cfg_idx;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = ppc_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_one_r   <= ppc_pkg::SetpointOneRst;
      sp_two_r   <= ppc_pkg::SetpointTwoRst;
      sp_three_r <= ppc_pkg::SetpointThreeRst;
      p_min_r    <= ppc_pkg::PressureMinRst;
      p_max_r    <= ppc_pkg::PressureMaxRst;
      toggle_r   <= ppc_pkg::ToggleRst;
      kp_r       <= ppc_pkg::KpRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ppc_pkg::REG_SETPOINT_ONE:    sp_one_r   <= cfg_pwdata[11:0];
        ppc_pkg::REG_SETPOINT_TWO:    sp_two_r   <= cfg_pwdata[11:0];
        ppc_pkg::REG_SETPOINT_THREE:  sp_three_r <= cfg_pwdata[11:0];
        ppc_pkg::REG_PRESSURE_MIN:    p_min_r    <= cfg_pwdata[11:0];
        ppc_pkg::REG_PRESSURE_MAX:    p_max_r    <= cfg_pwdata[11:0];
        ppc_pkg::REG_TOGGLE_INTERVAL: toggle_r   <= cfg_pwdata[13:0];
        ppc_pkg::REG_KP_Q16:          kp_r       <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ppc_pkg::REG_SETPOINT_ONE:    cfg_prdata = {20'd0, sp_one_r};
      ppc_pkg::REG_SETPOINT_TWO:    cfg_prdata = {20'd0, sp_two_r};
      ppc_pkg::REG_SETPOINT_THREE:  cfg_prdata = {20'd0, sp_three_r};
      ppc_pkg::REG_PRESSURE_MIN:    cfg_prdata = {20'd0, p_min_r};
      ppc_pkg::REG_PRESSURE_MAX:    cfg_prdata = {20'd0, p_max_r};
      ppc_pkg::REG_TOGGLE_INTERVAL: cfg_prdata = {18'd0, toggle_r};
      ppc_pkg::REG_KP_Q16:          cfg_prdata = {16'd0, kp_r};
      default:                      cfg_prdata = '0;
    endcase
  end

  // Input register stage.
  logic        s1_valid_r;
  logic [11:0] s1_press_r;
  logic        s1_level_r;
  logic [2:0]  s1_knob_r;
  logic        s1_tick_r;
  logic        advance;
  logic        in_acc;

  assign advance   = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_press_r <= in_tdata[11:0];
      s1_level_r <= in_tdata[12];
      s1_knob_r  <= in_tdata[15:13];
      s1_tick_r  <= in_tdata[16];
    end
  end

  // Controller state.
  ppc_pkg::mode_t mode_r, mode_nxt;
  logic [13:0]    ticks_r, ticks_nxt;
  logic           buzz_r, buzz_nxt;

  logic good;
  assign good = s1_level_r && (s1_press_r >= p_min_r) && (s1_press_r <= p_max_r);

  // Next mode: a good sample runs, a bad one alarms.
  always_comb begin
    case (mode_r)
      ppc_pkg::MODE_START,
      ppc_pkg::MODE_RUN,
      ppc_pkg::MODE_ALARM: mode_nxt = good ? ppc_pkg::MODE_RUN : ppc_pkg::MODE_ALARM;
      default:             mode_nxt = good ? ppc_pkg::MODE_RUN : ppc_pkg::MODE_ALARM;
    endcase
  end

  // Datapath and buzzer counter for the sample in the input register.
  logic [11:0] target;
  logic [11:0] err;
  logic [27:0] prod;
  logic [11:0] d_raw;
  logic [6:0]  duty;
  logic [13:0] base_ticks, inc_ticks;
  logic        base_buzz;
  logic [6:0]  motor_nxt;
  logic [5:0]  buzz_duty_nxt;
  logic [11:0] sp_nxt;

  always_comb begin
    if (s1_knob_r[0]) begin
      target = sp_one_r;
    end else if (s1_knob_r[1]) begin
      target = sp_two_r;
    end else if (s1_knob_r[2]) begin
      target = sp_three_r;
    end else begin
      target = 12'd0;
    end

    // Error is only used when positive; the subtraction cannot wrap then.
    err   = target - s1_press_r;
    prod  = {16'd0, err} * {12'd0, kp_r};
    d_raw = prod[27:16];
    if (target <= s1_press_r || d_raw < ppc_pkg::DutyMin) begin
      duty = 7'd0;
    end else if (d_raw >= ppc_pkg::DutyFull) begin
      duty = ppc_pkg::DutyFull[6:0];
    end else begin
      duty = d_raw[6:0];
    end

    // On entry to alarm the counter is preloaded so the first toggle comes
    // early, and the buzzer starts silent.
    if (mode_r != ppc_pkg::MODE_ALARM) begin
      base_ticks = (toggle_r >= ppc_pkg::PreloadGap) ? toggle_r - ppc_pkg::PreloadGap
                                                     : 14'd0;
      base_buzz  = 1'b0;
    end else begin
      base_ticks = ticks_r;
      base_buzz  = buzz_r;
    end
    inc_ticks = (s1_tick_r && base_ticks != ppc_pkg::TicksMax) ? base_ticks + 14'd1
                                                               : base_ticks;

    if (good) begin
      ticks_nxt     = ticks_r;
      buzz_nxt      = 1'b0;
      motor_nxt     = duty;
      buzz_duty_nxt = 6'd0;
      sp_nxt        = target;
    end else begin
      if (inc_ticks > toggle_r) begin
        ticks_nxt = 14'd0;
        buzz_nxt  = !base_buzz;
      end else begin
        ticks_nxt = inc_ticks;
        buzz_nxt  = base_buzz;
      end
      motor_nxt     = 7'd0;
      buzz_duty_nxt = buzz_nxt ? ppc_pkg::BuzzOnDuty : 6'd0;
      sp_nxt        = 12'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ppc_pkg::MODE_START;
      ticks_r <= 14'd0;
      buzz_r  <= 1'b0;
    end else if (advance) begin
      mode_r  <= mode_nxt;
      ticks_r <= ticks_nxt;
      buzz_r  <= buzz_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (advance) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tdata <= {4'd0, sp_nxt, !good, good, good, buzz_duty_nxt, motor_nxt};
    end
  end

endmodule

`default_nettype wire

### rtl/core/ppc_checker.sv
// Port-level checker for the pressure pump controller, with its bind.
// Depends on ppc_pkg for the output field positions.
`default_nettype none

module ppc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // A stalled result transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The pump duty never exceeds full scale.
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:0] <= 7'd100)
    else $error("motor duty above 100");

  // Exactly one indicator is lit.
  a_leds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ppc_pkg::OutRedBit] != out_tdata[ppc_pkg::OutGreenBit])
    else $error("red and green indicators agree");

  // In alarm the pump is stopped, unpowered and has no target.
  a_alarm_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[ppc_pkg::OutRedBit] |->
      out_tdata[6:0] == 7'd0 && !out_tdata[13] && out_tdata[27:16] == 12'd0)
    else $error("pump active in alarm");

  // Buzzer duty is off, or on only in alarm.
  a_buzzer: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[12:7] == 6'd0 ||
      (out_tdata[12:7] == 6'd50 && out_tdata[ppc_pkg::OutRedBit]))
    else $error("bad buzzer duty");

endmodule

bind pressure_pump_controller_with_alarm ppc_checker u_ppc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the pressure pump controller with alarm buzzer.
// Depends on ppc_pkg and pressure_pump_controller_with_alarm; it needs no other files.
// A transaction-level predictor computes each expected output transaction.
module tb_top;

  localparam int unsigned ClkHalf        = 6;
  localparam int unsigned RstCycles      = 4;
  localparam int unsigned SettleCycles   = 4;
  localparam int unsigned RunLimitCycles = 400000;

  // One input transaction. Fields are listed from the highest bit down, so
  // pressure sits in the lowest bits as on in_tdata.
  typedef struct packed {
    logic        tick;
    logic [2:0]  knob;
    logic        level_ok;
    logic [11:0] pressure;
  } sample_t;

  // One output transaction, laid out as the low 28 bits of out_tdata.
  typedef struct packed {
    logic [11:0] set_point;
    logic        red_led;
    logic        green_led;
    logic        relay_on;
    logic [5:0]  buzzer_duty;
    logic [6:0]  motor_duty;
  } outputs_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  // in_tdata: pressure[11:0], level_ok[12], knob[15:13], tick[16], zero pad
  logic [23:0]                 in_tdata = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  // out_tdata: motor_duty[6:0], buzzer_duty[12:7], relay_on[13],
  // green_led[14], red_led[15], set_point[27:16], zero pad
  logic [31:0]                 out_tdata;
  logic                        cfg_psel = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite = 1'b0;
  logic [ppc_pkg::AddrW-1:0]   cfg_paddr = '0;
  logic [ppc_pkg::DataW-1:0]   cfg_pwdata = '0;
  logic [ppc_pkg::DataW-1:0]   cfg_prdata;
  logic                        cfg_pready;

  // Predictor state: register copies, controller mode and the alarm counter.
  logic [15:0]    reg_shadow [ppc_pkg::REG_SETPOINT_ONE:ppc_pkg::REG_KP_Q16];
  ppc_pkg::mode_t ctl_mode;
  logic [13:0]    alarm_ticks;
  logic           buzzer_state;

  outputs_t    pending_outputs[$];
  int unsigned fault_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  pressure_pump_controller_with_alarm u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #(ClkHalf) clk = ~clk;
  end

  // The run is cut off here if the block hangs or drops a transaction.
  initial begin
    repeat (RunLimitCycles) @(posedge clk);
    $display("pressure_pump_controller_with_alarm: mismatch");
    $finish;
  end

  task automatic note_mismatch(input string what, input int unsigned want_v,
                               input int unsigned got_v);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%s: expected %0d, got %0d", what, want_v, got_v);
    end
  endtask

  // Advances the controller by one sample and returns the outputs it should
  // produce. A good sample needs the level bit and an in-range pressure.
  function automatic outputs_t step_controller(sample_t s);
    outputs_t    r;
    logic [11:0] target;
    logic [31:0] product;
    logic [11:0] duty;
    logic [13:0] interval;
    r = '0;
    interval = reg_shadow[ppc_pkg::REG_TOGGLE_INTERVAL][13:0];
    if (s.level_ok && s.pressure >= reg_shadow[ppc_pkg::REG_PRESSURE_MIN][11:0] &&
        s.pressure <= reg_shadow[ppc_pkg::REG_PRESSURE_MAX][11:0]) begin
      // The lowest knob pin wins.
      if (s.knob[0]) begin
        target = reg_shadow[ppc_pkg::REG_SETPOINT_ONE][11:0];
      end else if (s.knob[1]) begin
        target = reg_shadow[ppc_pkg::REG_SETPOINT_TWO][11:0];
      end else if (s.knob[2]) begin
        target = reg_shadow[ppc_pkg::REG_SETPOINT_THREE][11:0];
      end else begin
        target = '0;
      end
      ctl_mode = ppc_pkg::MODE_RUN;
      buzzer_state = 1'b0;
      // Only a positive error drives the pump; small duties are dropped and
      // large ones are held at full.
      if (target > s.pressure) begin
        product = 32'(target - s.pressure) * 32'(reg_shadow[ppc_pkg::REG_KP_Q16]);
        duty = product[27:16];
        if (duty >= ppc_pkg::DutyFull) begin
          r.motor_duty = ppc_pkg::DutyFull[6:0];
        end else if (duty >= ppc_pkg::DutyMin) begin
          r.motor_duty = duty[6:0];
        end
      end
      r.relay_on = 1'b1;
      r.green_led = 1'b1;
      r.set_point = target;
    end else begin
      // On entering alarm the counter is preloaded so the first toggle comes
      // early; intervals below the gap start from zero.
      if (ctl_mode != ppc_pkg::MODE_ALARM) begin
        ctl_mode = ppc_pkg::MODE_ALARM;
        buzzer_state = 1'b0;
        alarm_ticks = (interval >= ppc_pkg::PreloadGap) ? interval - ppc_pkg::PreloadGap
                                                        : '0;
      end
      if (s.tick && alarm_ticks < ppc_pkg::TicksMax) alarm_ticks++;
      if (alarm_ticks > interval) begin
        buzzer_state = ~buzzer_state;
        alarm_ticks = '0;
      end
      r.buzzer_duty = buzzer_state ? ppc_pkg::BuzzOnDuty : '0;
      r.red_led = 1'b1;
    end
    return r;
  endfunction

  // Output side: random back-pressure and the field-by-field comparison.
  always @(posedge clk) begin : check_outputs
    outputs_t got;
    outputs_t want;
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    got = out_tdata[27:0];
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outputs.size() == 0) begin
        note_mismatch("output transaction with none pending", 0, out_tdata);
      end else begin
        want = pending_outputs.pop_front();
        if (got.motor_duty !== want.motor_duty)
          note_mismatch("motor_duty", want.motor_duty, got.motor_duty);
        if (got.buzzer_duty !== want.buzzer_duty)
          note_mismatch("buzzer_duty", want.buzzer_duty, got.buzzer_duty);
        if (got.relay_on !== want.relay_on)
          note_mismatch("relay_on", want.relay_on, got.relay_on);
        if (got.green_led !== want.green_led)
          note_mismatch("green_led", want.green_led, got.green_led);
        if (got.red_led !== want.red_led)
          note_mismatch("red_led", want.red_led, got.red_led);
        if (got.set_point !== want.set_point)
          note_mismatch("set_point", want.set_point, got.set_point);
      end
    end
  end

  // Sends one sample, with random idle cycles ahead of it. Returns at the
  // clock edge where the transaction was accepted.
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_outputs.push_back(step_controller(s));
  endtask

  task automatic send_fields(input logic [11:0] pressure, input logic level_ok,
                             input logic [2:0] knob, input logic tick);
    sample_t s;
    s.pressure = pressure;
    s.level_ok = level_ok;
    s.knob = knob;
    s.tick = tick;
    send_sample(s);
  endtask

  // Holds the input side until every expected output has come back, then
  // leaves time for the pipeline to settle.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, access cycle, done when pready is high.
  task automatic apb_access(input logic is_write, input ppc_pkg::reg_idx_t idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= is_write;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_register(input ppc_pkg::reg_idx_t idx, input logic [31:0] value);
    logic [31:0] unused;
    apb_access(1'b1, idx, value, unused);
    case (idx)
      ppc_pkg::REG_TOGGLE_INTERVAL: reg_shadow[idx] = {2'b0, value[13:0]};
      ppc_pkg::REG_KP_Q16:          reg_shadow[idx] = value[15:0];
      ppc_pkg::REG_NONE:            ;
      default:                      reg_shadow[idx] = {4'b0, value[11:0]};
    endcase
  endtask

  task automatic check_registers();
    logic [31:0] rdata;
    for (int i = ppc_pkg::REG_SETPOINT_ONE; i <= ppc_pkg::REG_KP_Q16; i++) begin
      apb_access(1'b0, ppc_pkg::reg_idx_t'(i), '0, rdata);
      if (rdata !== {16'b0, reg_shadow[i]})
        note_mismatch("register readback", reg_shadow[i], rdata);
    end
  endtask

  // Rewrites every register once the block has gone idle.
  task automatic configure(input int unsigned sp1, input int unsigned sp2,
                           input int unsigned sp3, input int unsigned pmin,
                           input int unsigned pmax, input int unsigned interval,
                           input int unsigned kp);
    wait_for_results();
    write_register(ppc_pkg::REG_SETPOINT_ONE, sp1);
    write_register(ppc_pkg::REG_SETPOINT_TWO, sp2);
    write_register(ppc_pkg::REG_SETPOINT_THREE, sp3);
    write_register(ppc_pkg::REG_PRESSURE_MIN, pmin);
    write_register(ppc_pkg::REG_PRESSURE_MAX, pmax);
    write_register(ppc_pkg::REG_TOGGLE_INTERVAL, interval);
    write_register(ppc_pkg::REG_KP_Q16, kp);
    check_registers();
  endtask

  function automatic sample_t good_sample();
    sample_t s;
    s.pressure = 12'($urandom_range(reg_shadow[ppc_pkg::REG_PRESSURE_MAX],
                                    reg_shadow[ppc_pkg::REG_PRESSURE_MIN]));
    s.level_ok = 1'b1;
    s.knob = 3'($urandom_range(7));
    s.tick = 1'($urandom_range(1));
    return s;
  endfunction

  // A faulty sample: low level, or a pressure below or above the window.
  function automatic sample_t fault_sample(input int unsigned tick_pct);
    sample_t     s;
    int unsigned pick;
    s.pressure = 12'($urandom_range(4095));
    s.level_ok = 1'($urandom_range(1));
    s.knob = 3'($urandom_range(7));
    s.tick = ($urandom_range(99) < tick_pct);
    pick = $urandom_range(2);
    if (pick == 1 && reg_shadow[ppc_pkg::REG_PRESSURE_MIN] > 0) begin
      s.pressure = 12'($urandom_range(reg_shadow[ppc_pkg::REG_PRESSURE_MIN] - 1, 0));
    end else if (pick == 2 && reg_shadow[ppc_pkg::REG_PRESSURE_MAX] < 4095) begin
      s.pressure = 12'($urandom_range(4095, reg_shadow[ppc_pkg::REG_PRESSURE_MAX] + 1));
    end else begin
      s.level_ok = 1'b0;
    end
    return s;
  endfunction

  function automatic sample_t noise_sample();
    logic [16:0] bits;
    bits = 17'($urandom);
    return sample_t'(bits);
  endfunction

  // Random traffic built from episodes: stretches of good samples, alarm
  // stretches with dense or sparse ticks, and short bursts of raw noise.
  task automatic run_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int unsigned tick_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      // Now and then the sender holds off until the output side is empty.
      if (pick < 3) wait_for_results();
      if (pick < 45 &&
          reg_shadow[ppc_pkg::REG_PRESSURE_MIN] <= reg_shadow[ppc_pkg::REG_PRESSURE_MAX]) begin
        len = $urandom_range(24, 1);
        repeat (len) send_sample(good_sample());
      end else if (pick < 80) begin
        len = $urandom_range(60, 1);
        case ($urandom_range(2))
          0:       tick_pct = 100;
          1:       tick_pct = 50;
          default: tick_pct = 10;
        endcase
        repeat (len) send_sample(fault_sample(tick_pct));
      end else begin
        len = $urandom_range(8, 1);
        repeat (len) send_sample(noise_sample());
      end
      sent += len;
    end
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic test_reset_values();
    check_registers();
  endtask

  // Hand-picked samples under the reset configuration: duty floor and clamp,
  // window edges, knob priority, no knob, and alarm entry from start mode.
  task automatic test_directed_samples();
    set_idling(0, 0);
    send_fields(12'd4095, 1'b0, 3'b000, 1'b1);
    send_fields(12'd700,  1'b1, 3'b001, 1'b0);
    send_fields(12'd695,  1'b1, 3'b001, 1'b0);
    send_fields(12'd300,  1'b1, 3'b010, 1'b1);
    send_fields(12'd2000, 1'b1, 3'b100, 1'b0);
    send_fields(12'd500,  1'b1, 3'b111, 1'b1);
    send_fields(12'd600,  1'b1, 3'b110, 1'b0);
    send_fields(12'd1000, 1'b1, 3'b000, 1'b1);
    send_fields(12'd800,  1'b1, 3'b101, 1'b0);
    send_fields(12'd299,  1'b1, 3'b001, 1'b1);
    send_fields(12'd2001, 1'b1, 3'b001, 1'b0);
    send_fields(12'd1000, 1'b0, 3'b010, 1'b1);
    send_fields(12'd4095, 1'b1, 3'b111, 1'b1);
    send_fields(12'd0,    1'b0, 3'b000, 1'b0);
    send_fields(12'd1999, 1'b1, 3'b011, 1'b1);
    send_fields(12'd1050, 1'b1, 3'b010, 1'b0);
  endtask

  // Register values at their limits, an empty window, a one-value window and
  // a write to an address with no register behind it.
  task automatic test_register_extremes();
    set_idling(0, 0);
    configure(4095, 0, 2048, 0, 4095, 16000, 65535);
    send_fields(12'd0,    1'b1, 3'b001, 1'b1);
    send_fields(12'd0,    1'b1, 3'b010, 1'b0);
    send_fields(12'd2027, 1'b1, 3'b100, 1'b0);
    send_fields(12'd2026, 1'b1, 3'b100, 1'b1);
    send_fields(12'd4095, 1'b1, 3'b001, 1'b0);
    send_fields(12'd4095, 1'b0, 3'b100, 1'b1);
    configure(0, 4095, 1, 4095, 0, 500, 0);
    send_fields(12'd0,    1'b1, 3'b001, 1'b1);
    send_fields(12'd4095, 1'b1, 3'b010, 1'b1);
    send_fields(12'd2048, 1'b1, 3'b100, 1'b0);
    wait_for_results();
    write_register(ppc_pkg::REG_NONE, 32'h0000_0ABC);
    check_registers();
    configure(4095, 4095, 4095, 2048, 2048, 500, 65535);
    send_fields(12'd2048, 1'b1, 3'b001, 1'b0);
    send_fields(12'd2047, 1'b1, 3'b010, 1'b1);
    send_fields(12'd2049, 1'b1, 3'b100, 1'b1);
    send_fields(12'd2048, 1'b1, 3'b000, 1'b0);
  endtask

  // Long alarm stretches: the buzzer turns on at an interval equal to the preload
  // gap, turns off again after a short interval written while the alarm lasts,
  // and stays silent when the counter saturates.
  task automatic test_buzzer_cadence();
    set_idling(34, 34);
    configure(800, 1100, 1400, 300, 2000, 500, 13108);
    send_fields(12'd1000, 1'b1, 3'b001, 1'b0);
    repeat (505) send_fields(12'd100, 1'b1, 3'b001, 1'b1);
    configure(800, 1100, 1400, 300, 2000, 8, 13108);
    repeat (12) send_fields(12'd100, 1'b1, 3'b001, 1'b1);
    send_fields(12'd1000, 1'b1, 3'b001, 1'b0);
    set_idling(0, 0);
    configure(800, 1100, 1400, 300, 2000, ppc_pkg::TicksMax, 13108);
    send_fields(12'd1000, 1'b1, 3'b001, 1'b0);
    repeat (510) send_fields(12'd2500, 1'b1, 3'b010, 1'b1);
    send_fields(12'd1000, 1'b1, 3'b001, 1'b0);
  endtask

  // Random episodes under four idling patterns, each with its own settings.
  // Short toggle intervals keep the buzzer busy within short alarm stretches.
  task automatic test_random_traffic();
    set_idling(0, 0);
    configure($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
              200, 3000, 0, 65535);
    run_traffic(40);
    set_idling(78, 0);
    configure($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
              0, 4095, 5, $urandom_range(65535));
    run_traffic(40);
    set_idling(0, 78);
    configure($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
              $urandom_range(1500), $urandom_range(4095, 2000), 30,
              $urandom_range(65535));
    run_traffic(40);
    set_idling(34, 34);
    configure($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
              100, 3900, 12, $urandom_range(65535));
    run_traffic(40);
  endtask

  initial begin
    reg_shadow[ppc_pkg::REG_SETPOINT_ONE]    = {4'b0, ppc_pkg::SetpointOneRst};
    reg_shadow[ppc_pkg::REG_SETPOINT_TWO]    = {4'b0, ppc_pkg::SetpointTwoRst};
    reg_shadow[ppc_pkg::REG_SETPOINT_THREE]  = {4'b0, ppc_pkg::SetpointThreeRst};
    reg_shadow[ppc_pkg::REG_PRESSURE_MIN]    = {4'b0, ppc_pkg::PressureMinRst};
    reg_shadow[ppc_pkg::REG_PRESSURE_MAX]    = {4'b0, ppc_pkg::PressureMaxRst};
    reg_shadow[ppc_pkg::REG_TOGGLE_INTERVAL] = {2'b0, ppc_pkg::ToggleRst};
    reg_shadow[ppc_pkg::REG_KP_Q16]          = ppc_pkg::KpRst;
    ctl_mode = ppc_pkg::MODE_START;
    alarm_ticks = '0;
    buzzer_state = 1'b0;

    repeat (RstCycles) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_directed_samples();
    test_register_extremes();
    test_buzzer_cadence();
    test_random_traffic();

    wait_for_results();
    repeat (2 * SettleCycles) @(posedge clk);
    if (fault_count == 0) begin
      $display("pressure_pump_controller_with_alarm: match");
    end else begin
      $display("pressure_pump_controller_with_alarm: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/ppc_pkg.sv
rtl/core/pressure_pump_controller_with_alarm.sv
rtl/core/ppc_checker.sv
sim/tb_top.sv
